// ===== hw/rtl/rpid_pkg.sv =====
package rpid_pkg;

  localparam int unsigned TableDepthDef = 256;
  localparam int unsigned OutLanesDef   = 16;
  localparam int unsigned InDepth       = 2;
  localparam int unsigned OutDepth      = 4;

  typedef enum logic [1:0] {
    PH_CONTROL,
    PH_LITERAL,
    PH_RUNVAL
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED,
    ST_EXTRACT,
    ST_PUT,
    ST_TAIL,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    CFG_INDEXED_MODE,
    CFG_INDEX_BITS,
    CFG_OUT_LEN,
    CFG_PACKED_LEN,
    CFG_TABLE_SIZE
  } cfg_reg_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] table_slot;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic        last;
    logic [4:0]  byte_count;
    logic [63:0] out_bytes_hi;
    logic [63:0] out_bytes_lo;
  } res_t;

  typedef struct packed {
    logic        valid;
    cfg_reg_e    index;
    logic [15:0] data;
  } cfg_wr_t;

endpackage

// ===== hw/rtl/rle_palette_index_decompressor_unit.sv =====
// channel   direction  handshake                  payload
// input     in         push / full                mode_i, table_slot_i, byte_value_i
// result    out        empty / pop                out_bytes_lo_o, out_bytes_hi_o,
//                                                 byte_count_o, last_o
// config    in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// palette loads are written from idle; control bytes go on to the tail state, bytes
// of a finished frame to the finish state; plain bytes are put from the feed state,
// indexed bytes via feed, extract and put, with a one-port palette read per index
// a two-entry request queue feeds the decoder, a four-entry result queue follows it
// results back up into the decoder only while the result queue is full
// reset clears queues, frame state and registers; the palette is not cleared
module rle_palette_index_decompressor_unit #(
  parameter int unsigned TABLE_DEPTH = rpid_pkg::TableDepthDef,
  parameter int unsigned OUT_LANES   = rpid_pkg::OutLanesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        mode_i,
  input  logic [7:0]  table_slot_i,
  input  logic [7:0]  byte_value_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_bytes_lo_o,
  output logic [63:0] out_bytes_hi_o,
  output logic [4:0]  byte_count_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import rpid_pkg::*;

  item_t   in_item, q_item;
  logic    q_empty, q_pop;
  res_t    res_w, res_r;
  logic    res_wr, res_full;
  cfg_wr_t cfg;

  assign cfg_ready_o = 1'b1;
  assign cfg.valid = cfg_valid_i;
  assign cfg.index = cfg_reg_e'(cfg_index_i);
  assign cfg.data  = cfg_data_i;

  assign in_item.mode       = mode_i;
  assign in_item.table_slot = table_slot_i;
  assign in_item.byte_value = byte_value_i;

  rpid_fifo #(.Width($bits(item_t)), .Depth(InDepth)) u_in_q (
    .clk_i, .rst_ni,
    .wr_en_i(push && !full), .wdata_i(in_item), .full_o(full),
    .rd_en_i(q_pop), .rdata_o(q_item), .empty_o(q_empty)
  );

  rpid_core #(.TableDepth(TABLE_DEPTH), .OutLanes(OUT_LANES)) u_core (
    .clk_i, .rst_ni,
    .cfg_i(cfg),
    .item_valid_i(!q_empty), .item_i(q_item), .item_pop_o(q_pop),
    .res_full_i(res_full), .res_wr_o(res_wr), .res_o(res_w)
  );

  rpid_fifo #(.Width($bits(res_t)), .Depth(OutDepth)) u_out_q (
    .clk_i, .rst_ni,
    .wr_en_i(res_wr), .wdata_i(res_w), .full_o(res_full),
    .rd_en_i(pop && !empty), .rdata_o(res_r), .empty_o(empty)
  );

  assign out_bytes_lo_o = res_r.out_bytes_lo;
  assign out_bytes_hi_o = res_r.out_bytes_hi;
  assign byte_count_o   = res_r.byte_count;
  assign last_o         = res_r.last;

endmodule

// ===== hw/rtl/rpid_fifo.sv =====
module rpid_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hw/rtl/rpid_core.sv =====
module rpid_core #(
  parameter int unsigned TableDepth = rpid_pkg::TableDepthDef,
  parameter int unsigned OutLanes   = rpid_pkg::OutLanesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rpid_pkg::cfg_wr_t cfg_i,
  input  logic             item_valid_i,
  input  rpid_pkg::item_t  item_i,
  output logic             item_pop_o,
  input  logic             res_full_i,
  output logic             res_wr_o,
  output rpid_pkg::res_t   res_o
);
  import rpid_pkg::*;

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned LaneW = $clog2(OutLanes);
  localparam int unsigned FillW = $clog2(OutLanes + 1);

  // configuration
  logic        imode_q;
  logic [3:0]  ibits_q;
  logic [15:0] olen_q, plen_q;
  logic [7:0]  tsize_q;
  logic [3:0]  ebits;

  state_e      state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [6:0]  lit_q, lit_d, rep_q, rep_d;
  logic [15:0] rle_q, rle_d, emit_q, emit_d;
  logic [14:0] buf_q, buf_d;
  logic [3:0]  fill_q, fill_d;
  logic [7:0]  lane_q [OutLanes];
  logic [7:0]  lane_d [OutLanes];
  logic [FillW-1:0] lfill_q, lfill_d;
  logic [7:0]  b_q, b_d;
  logic        oob_q, oob_d, fin_q, fin_d;
  logic [7:0]  pal_mem [TableDepth];
  logic [7:0]  pal_q;
  logic        pal_we, pal_re;
  logic [7:0]  idx;
  logic [3:0]  shamt;

  // put unit
  logic [7:0]       put_val;
  logic             put_fin;
  logic [7:0]       lane_put [OutLanes];
  logic [FillW-1:0] put_fill;
  logic [16:0]      put_emit;
  logic             put_stop, put_send;

  logic frame_done;
  logic [7:0]       src [OutLanes];
  logic [FillW-1:0] src_cnt;

  assign ebits = (ibits_q == 4'd0) ? 4'd1 : ((ibits_q > 4'd8) ? 4'd8 : ibits_q);
  assign frame_done = ({1'b0, emit_q} >= {1'b0, olen_q}) || (imode_q && rle_q >= plen_q);
  assign shamt = fill_q - ebits;
  assign idx = 8'((buf_q >> shamt) & ((15'd1 << ebits) - 15'd1));

  always_comb begin
    put_val  = (state_q == ST_PUT) ? (oob_q ? 8'd0 : pal_q) : b_q;
    put_fin  = (state_q == ST_PUT) && fin_q;
    lane_put = lane_q;
    lane_put[lfill_q[LaneW-1:0]] = put_val;
    put_fill = lfill_q + 1'b1;
    put_emit = {1'b0, emit_q} + 17'd1;
    put_stop = put_fin || (put_emit >= {1'b0, olen_q});
    put_send = put_stop || (put_fill == FillW'(OutLanes));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i && item_i.mode) begin
          if (frame_done) begin
            state_d = ST_FINISH;
          end else if (phase_q == PH_CONTROL) begin
            state_d = ST_TAIL;
          end else begin
            state_d = ST_FEED;
          end
        end
      end
      ST_FEED: begin
        if (rep_q == '0) begin
          state_d = ST_TAIL;
        end else if (imode_q) begin
          state_d = ST_EXTRACT;
        end else if (!res_full_i && put_stop) begin
          state_d = ST_IDLE;
        end
      end
      ST_EXTRACT: state_d = (fill_q >= ebits) ? ST_PUT : ST_FEED;
      ST_PUT: begin
        if (!res_full_i) begin
          state_d = put_stop ? ST_IDLE : ST_EXTRACT;
        end
      end
      ST_TAIL: begin
        if (lfill_q <= FillW'(OutLanes / 2) || !res_full_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (lfill_q == '0 || !res_full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    lit_d   = lit_q;
    rep_d   = rep_q;
    rle_d   = rle_q;
    emit_d  = emit_q;
    buf_d   = buf_q;
    fill_d  = fill_q;
    lane_d  = lane_q;
    lfill_d = lfill_q;
    b_d     = b_q;
    oob_d   = oob_q;
    fin_d   = fin_q;
    item_pop_o = 1'b0;
    pal_we  = 1'b0;
    pal_re  = 1'b0;
    res_wr_o = 1'b0;
    src     = lane_q;
    src_cnt = lfill_q;
    res_o.last = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          b_d = item_i.byte_value;
          if (!item_i.mode) begin
            pal_we = ({1'b0, item_i.table_slot} < 9'(TableDepth));
          end else if (!frame_done) begin
            unique case (phase_q)
              PH_LITERAL: rep_d = 7'd1;
              PH_RUNVAL:  rep_d = lit_q;
              default: begin
                lit_d = item_i.byte_value[6:0];
                if (item_i.byte_value[7]) begin
                  phase_d = (item_i.byte_value[6:0] != '0) ? PH_LITERAL : PH_CONTROL;
                end else begin
                  phase_d = PH_RUNVAL;
                end
              end
            endcase
          end
        end
      end
      ST_FEED: begin
        if (rep_q == '0) begin
          if (phase_q == PH_LITERAL) begin
            lit_d = lit_q - 1'b1;
            if (lit_q == 7'd1) begin
              phase_d = PH_CONTROL;
            end
          end else begin
            lit_d   = '0;
            phase_d = PH_CONTROL;
          end
        end else if (imode_q) begin
          rep_d  = rep_q - 1'b1;
          rle_d  = rle_q + 1'b1;
          buf_d  = {buf_q[6:0], b_q};
          fill_d = fill_q + 4'd8;
        end else if (!res_full_i) begin
          rep_d = rep_q - 1'b1;
        end
      end
      ST_EXTRACT: begin
        if (fill_q >= ebits) begin
          pal_re = 1'b1;
          fill_d = shamt;
          buf_d  = buf_q & ((15'd1 << shamt) - 15'd1);
          fin_d  = (rle_q >= plen_q) && (shamt < ebits);
          oob_d  = (idx >= tsize_q) || ({1'b0, idx} >= 9'(TableDepth));
        end
      end
      ST_TAIL: begin
        if (lfill_q > FillW'(OutLanes / 2) && !res_full_i) begin
          res_wr_o = 1'b1;
          lfill_d  = '0;
        end
      end
      ST_FINISH: begin
        if (lfill_q == '0 || !res_full_i) begin
          res_wr_o   = (lfill_q != '0);
          res_o.last = 1'b1;
          phase_d = PH_CONTROL;
          lit_d   = '0;
          rle_d   = '0;
          buf_d   = '0;
          fill_d  = '0;
          emit_d  = '0;
          lfill_d = '0;
        end
      end
      default: ;
    endcase

    // byte placement shared by plain feed and palette put
    if (!res_full_i && ((state_q == ST_PUT) ||
        (state_q == ST_FEED && rep_q != '0 && !imode_q))) begin
      lane_d  = lane_put;
      lfill_d = put_fill;
      emit_d  = put_emit[15:0];
      src     = lane_put;
      src_cnt = put_fill;
      if (put_send) begin
        res_wr_o   = 1'b1;
        res_o.last = put_stop;
        lfill_d    = '0;
      end
      if (put_stop) begin
        phase_d = PH_CONTROL;
        lit_d   = '0;
        rep_d   = '0;
        rle_d   = '0;
        buf_d   = '0;
        fill_d  = '0;
        emit_d  = '0;
      end
    end

    res_o.byte_count = 5'(src_cnt);
    for (int i = 0; i < 8; i++) begin
      res_o.out_bytes_lo[8*i +: 8] = (FillW'(i) < src_cnt) ? src[i] : 8'd0;
      res_o.out_bytes_hi[8*i +: 8] = (FillW'(i + 8) < src_cnt) ? src[i + 8] : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imode_q <= 1'b0;
      ibits_q <= 4'd8;
      olen_q  <= '0;
      plen_q  <= '0;
      tsize_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_INDEXED_MODE: imode_q <= cfg_i.data[0];
        CFG_INDEX_BITS:   ibits_q <= cfg_i.data[3:0];
        CFG_OUT_LEN:      olen_q  <= cfg_i.data;
        CFG_PACKED_LEN:   plen_q  <= cfg_i.data;
        CFG_TABLE_SIZE:   tsize_q <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_CONTROL;
      lit_q   <= '0;
      rep_q   <= '0;
      rle_q   <= '0;
      emit_q  <= '0;
      buf_q   <= '0;
      fill_q  <= '0;
      lfill_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      lit_q   <= lit_d;
      rep_q   <= rep_d;
      rle_q   <= rle_d;
      emit_q  <= emit_d;
      buf_q   <= buf_d;
      fill_q  <= fill_d;
      lfill_q <= lfill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
    b_q    <= b_d;
    oob_q  <= oob_d;
    fin_q  <= fin_d;
  end

  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[item_i.table_slot[AddrW-1:0]] <= item_i.byte_value;
    end
    if (pal_re) begin
      pal_q <= pal_mem[idx[AddrW-1:0]];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) res_wr_o |-> !res_full_i)
    else $error("result write into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) lfill_q < FillW'(OutLanes))
    else $error("lane fill overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PUT |-> $past(state_q) == ST_EXTRACT || $past(state_q) == ST_PUT)
    else $error("palette put without lookup");
  assert property (@(posedge clk_i) disable iff (!rst_ni) item_pop_o |-> state_q == ST_IDLE)
    else $error("item taken while busy");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import rpid_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned SettleCycles = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic        mode_i;
  logic [7:0]  table_slot_i;
  logic [7:0]  byte_value_i;
  logic        empty;
  logic        pop;
  logic [63:0] out_bytes_lo_o;
  logic [63:0] out_bytes_hi_o;
  logic [4:0]  byte_count_o;
  logic        last_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  rle_palette_index_decompressor_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .mode_i(mode_i),
    .table_slot_i(table_slot_i), .byte_value_i(byte_value_i), .empty(empty), .pop(pop),
    .out_bytes_lo_o(out_bytes_lo_o), .out_bytes_hi_o(out_bytes_hi_o),
    .byte_count_o(byte_count_o), .last_o(last_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // decoder copy
  bit          m_indexed;
  bit [3:0]    m_index_bits;
  int unsigned m_out_len;
  int unsigned m_packed_len;
  int unsigned m_table_size;
  phase_e      m_phase;
  int unsigned m_lit_left;
  int unsigned m_rle_count;
  int unsigned m_bit_buf;
  int unsigned m_bit_fill;
  int unsigned m_emitted;
  logic [7:0]  m_lanes [16];
  int unsigned m_lane_fill;
  logic [7:0]  m_palette [256];
  bit          m_stopped;

  res_t        expected_q [$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned cfg_writes;
  bit          quiet;
  int unsigned pop_stall;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void clear_frame();
    m_phase = PH_CONTROL;
    m_lit_left = 0;
    m_rle_count = 0;
    m_bit_buf = 0;
    m_bit_fill = 0;
    m_emitted = 0;
    m_lane_fill = 0;
    for (int i = 0; i < 16; i++) m_lanes[i] = '0;
  endfunction

  function automatic void emit_lanes(bit last);
    res_t r;
    r = '0;
    for (int unsigned i = 0; i < m_lane_fill && i < 16; i++) begin
      if (i < 8) r.out_bytes_lo |= 64'(m_lanes[i]) << (8 * i);
      else r.out_bytes_hi |= 64'(m_lanes[i]) << (8 * (i - 8));
    end
    r.byte_count = 5'(m_lane_fill);
    r.last = last;
    expected_q.push_back(r);
    m_lane_fill = 0;
  endfunction

  function automatic void finish_frame();
    if (m_lane_fill > 0) emit_lanes(1'b1);
    clear_frame();
    m_stopped = 1;
  endfunction

  function automatic void put_byte(logic [7:0] v, bit fin);
    if (m_lane_fill < 16) begin
      m_lanes[m_lane_fill] = v;
      m_lane_fill++;
    end
    m_emitted++;
    if (fin || m_emitted >= m_out_len) finish_frame();
    else if (m_lane_fill >= 16) emit_lanes(1'b0);
  endfunction

  function automatic void take_decoded(logic [7:0] d);
    int unsigned bits;
    int unsigned idx;
    bit fin;
    if (m_stopped) return;
    if (!m_indexed) begin
      put_byte(d, 1'b0);
      return;
    end
    bits = (m_index_bits == 0) ? 1 : (m_index_bits > 8) ? 8 : m_index_bits;
    m_rle_count++;
    m_bit_buf = ((m_bit_buf << 8) | d) & 32'h7fff;
    m_bit_fill += 8;
    while (!m_stopped && m_bit_fill >= bits) begin
      idx = (m_bit_buf >> (m_bit_fill - bits)) & ((1 << bits) - 1);
      m_bit_fill -= bits;
      m_bit_buf &= (1 << m_bit_fill) - 1;
      fin = m_rle_count >= m_packed_len && m_bit_fill < bits;
      put_byte((idx >= m_table_size) ? 8'h00 : m_palette[idx], fin);
    end
  endfunction

  function automatic void decode_request(logic mode, logic [7:0] slot, logic [7:0] b);
    m_stopped = 0;
    if (!mode) begin
      m_palette[slot] = b;
      return;
    end
    if (m_emitted >= m_out_len || (m_indexed && m_rle_count >= m_packed_len)) begin
      finish_frame();
      return;
    end
    if (m_phase == PH_LITERAL) begin
      take_decoded(b);
      if (!m_stopped) begin
        m_lit_left = (m_lit_left - 1) & 32'h7f;
        if (m_lit_left == 0) m_phase = PH_CONTROL;
      end
    end else if (m_phase == PH_RUNVAL) begin
      for (int unsigned i = 0; i < m_lit_left && !m_stopped; i++) take_decoded(b);
      if (!m_stopped) begin
        m_lit_left = 0;
        m_phase = PH_CONTROL;
      end
    end else if (b[7]) begin
      m_lit_left = b & 8'h7f;
      m_phase = (m_lit_left != 0) ? PH_LITERAL : PH_CONTROL;
    end else begin
      m_lit_left = b;
      m_phase = PH_RUNVAL;
    end
    if (!m_stopped && m_lane_fill > 8) emit_lanes(1'b0);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && pop && !empty) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result lo %h hi %h count %0d last %0d", $time,
                 out_bytes_lo_o, out_bytes_hi_o, byte_count_o, last_o);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_bytes_lo_o !== exp_r.out_bytes_lo) begin
          $display("%0t out_bytes_lo exp %h got %h", $time, exp_r.out_bytes_lo, out_bytes_lo_o);
          errors++;
        end
        if (out_bytes_hi_o !== exp_r.out_bytes_hi) begin
          $display("%0t out_bytes_hi exp %h got %h", $time, exp_r.out_bytes_hi, out_bytes_hi_o);
          errors++;
        end
        if (byte_count_o !== exp_r.byte_count) begin
          $display("%0t byte_count exp %0d got %0d", $time, exp_r.byte_count, byte_count_o);
          errors++;
        end
        if (last_o !== exp_r.last) begin
          $display("%0t last exp %0d got %0d", $time, exp_r.last, last_o);
          errors++;
        end
      end
    end
  end

  // pop side stalls
  always @(posedge clk_i) begin
    if (quiet) begin
      pop <= 1'b1;
    end else if (pop_stall > 0) begin
      pop <= 1'b0;
      pop_stall <= pop_stall - 1;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 9) == 0)
        pop_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one request, called at a rising edge
  task automatic send(logic mode, logic [7:0] slot, logic [7:0] b);
    int unsigned gap;
    push <= 1'b1;
    mode_i <= mode;
    table_slot_i <= slot;
    byte_value_i <= b;
    do @(posedge clk_i); while (full);
    decode_request(mode, slot, b);
    items_sent++;
    gap = 0;
    if (!quiet) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
        6: gap = $urandom_range(10, 40);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_reg_e idx, int unsigned data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= 16'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_INDEXED_MODE: m_indexed = data[0];
      CFG_INDEX_BITS:   m_index_bits = data[3:0];
      CFG_OUT_LEN:      m_out_len = data & 32'hffff;
      CFG_PACKED_LEN:   m_packed_len = data & 32'hffff;
      CFG_TABLE_SIZE:   m_table_size = data & 32'hff;
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned ixm, int unsigned bits, int unsigned olen,
                           int unsigned plen, int unsigned tsize);
    settle();
    write_cfg(CFG_INDEXED_MODE, ixm);
    write_cfg(CFG_INDEX_BITS, bits);
    write_cfg(CFG_OUT_LEN, olen);
    write_cfg(CFG_PACKED_LEN, plen);
    write_cfg(CFG_TABLE_SIZE, tsize);
  endtask

  task automatic send_packet();
    int unsigned n;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8: begin
        n = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
        send(1'b1, 8'($urandom), 8'h80 | 8'(n));
        repeat (n) send(1'b1, 8'($urandom), 8'($urandom));
      end
      9, 10, 11, 12, 13, 14, 15: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 20);
        send(1'b1, 8'($urandom), 8'(n));
        send(1'b1, 8'($urandom), 8'($urandom));
      end
      16, 17: send(1'b0, 8'($urandom), 8'($urandom));
      default: send(1'b1, 8'($urandom), 8'($urandom));
    endcase
  endtask

  task automatic test_plain_directed();
    configure(0, 8, 40, 0, 0);
    send(1'b1, 8'h00, 8'h85);
    send(1'b1, 8'h00, 8'h00);
    send(1'b1, 8'hff, 8'hff);
    send(1'b1, 8'h00, 8'h01);
    send(1'b1, 8'h00, 8'h80);
    send(1'b1, 8'h00, 8'h7f);
    send(1'b1, 8'h00, 8'h03);
    send(1'b1, 8'h00, 8'haa);
    send(1'b1, 8'h00, 8'h80);
    send(1'b1, 8'h00, 8'h00);
    send(1'b1, 8'h00, 8'h11);
    send(1'b1, 8'h00, 8'h7f);
    send(1'b1, 8'h00, 8'h55);
    configure(0, 8, 0, 0, 0);
    send(1'b1, 8'h00, 8'h83);
    send(1'b1, 8'h00, 8'h12);
  endtask

  task automatic test_palette_load();
    for (int i = 0; i < 256; i++) send(1'b0, 8'(i), 8'($urandom));
  endtask

  task automatic test_indexed_directed();
    configure(1, 1, 65535, 3, 2);
    send(1'b1, 8'h00, 8'h83);
    send(1'b1, 8'h00, 8'ha5);
    send(1'b1, 8'h00, 8'h0f);
    send(1'b1, 8'h00, 8'hf0);
    send(1'b1, 8'h00, 8'h81);
    configure(1, 8, 200, 65535, 255);
    send(1'b1, 8'h00, 8'h7f);
    send(1'b1, 8'h00, 8'hff);
    configure(1, 0, 30, 20, 1);
    send(1'b1, 8'h00, 8'h05);
    send(1'b1, 8'h00, 8'h81);
    configure(1, 15, 9, 0, 255);
    send(1'b1, 8'h00, 8'h82);
    configure(1, 3, 65535, 12, 5);
    send(1'b1, 8'h00, 8'h0c);
    send(1'b1, 8'h00, 8'h6b);
  endtask

  task automatic test_random(int unsigned target);
    int unsigned start;
    int unsigned phase_len;
    for (int p = 0; items_sent < target; p++) begin
      configure($urandom_range(0, 1), $urandom_range(0, 15),
                ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(1, 150),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) * 65535
                                            : $urandom_range(1, 40),
                $urandom_range(0, 255));
      quiet = (p % 5 == 2);
      phase_len = $urandom_range(30, 50);
      start = items_sent;
      while (items_sent - start < phase_len) send_packet();
      quiet = 0;
    end
  endtask

  initial begin
    clk_i = 0;
    rst_ni = 0;
    push = 0;
    pop = 0;
    mode_i = 0;
    table_slot_i = 0;
    byte_value_i = 0;
    cfg_valid_i = 0;
    cfg_index_i = CFG_INDEXED_MODE;
    cfg_data_i = 0;
    errors = 0;
    cycles = 0;
    items_sent = 0;
    results_seen = 0;
    cfg_writes = 0;
    quiet = 0;
    pop_stall = 0;
    m_indexed = 0;
    m_index_bits = 8;
    m_out_len = 0;
    m_packed_len = 0;
    m_table_size = 0;
    for (int i = 0; i < 256; i++) m_palette[i] = '0;
    clear_frame();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_directed();
    test_palette_load();
    test_indexed_directed();
    test_random(370);

    settle();
    $display("sent %0d requests over %0d config writes, checked %0d results",
             items_sent, cfg_writes, results_seen);
    $display("plain and indexed frames, index widths 0 to 15, truncation and exhaustion");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
